// ----- src/lsep_pkg.sv -----
package lsep_pkg;

	localparam int unsigned LED_COUNT = 64;
	localparam int unsigned DYN_RANGE = 256;
	localparam int unsigned SWEEP_HALF = LED_COUNT / 10;

	localparam int IndexW = 16;
	localparam int TimeW = 32;
	localparam int DimW = 9;
	localparam int ColorW = 8;
	localparam int RgbW = 3 * ColorW;
	localparam int PosW = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam int DivSteps = TimeW + PosW;
	localparam int LimitW = DimW + IndexW;
	localparam int RegionW = IndexW + 3;
	localparam int SweepW = IndexW + 3;

	localparam int FifoDepth = 2;
	localparam int PtrW = $clog2(FifoDepth);
	localparam int CntW = $clog2(FifoDepth + 1);

	localparam logic [1:0] EFFECT_FIXED = 2'd0;
	localparam logic [1:0] EFFECT_RAINBOW = 2'd1;
	localparam logic [1:0] EFFECT_SWEEP = 2'd2;

	typedef enum logic [1:0] {
		MASK_GRADUAL,
		MASK_OUTSIDE_IN,
		MASK_INSIDE_OUT,
		MASK_LEFT_RIGHT
	} mask_mode_t;

	localparam logic [CfgIdxW-1:0] REG_EFFECT_SELECT = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MASK_MODE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CYCLE_LENGTH = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_EFFECT_BRIGHTNESS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FIXED_RGB = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_FIXED_BRIGHTNESS = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SWEEP_RGB = 3'd6;

	typedef struct packed {
		logic [IndexW-1:0] pixel_index;
		logic [TimeW-1:0]  time_now;
		logic [DimW-1:0]   dim_level;
	} pixel_t;

	typedef struct packed {
		logic [IndexW-1:0] led_index;
		logic [ColorW-1:0] red;
		logic [ColorW-1:0] green;
		logic [ColorW-1:0] blue;
		logic [ColorW-1:0] brightness;
	} result_t;

	typedef struct packed {
		logic [1:0]        effect_select;
		mask_mode_t        mask_mode;
		logic [TimeW-1:0]  cycle_length;
		logic [ColorW-1:0] effect_brightness;
		logic [RgbW-1:0]   fixed_rgb;
		logic [ColorW-1:0] fixed_brightness;
		logic [RgbW-1:0]   sweep_rgb;
	} cfg_t;

	typedef struct packed {
		pixel_t pixel;
		logic   lit;
	} entry_t;

	localparam cfg_t CFG_RESET = '{
		effect_select: EFFECT_FIXED,
		mask_mode: MASK_OUTSIDE_IN,
		cycle_length: 32'd10000,
		effect_brightness: 8'd255,
		fixed_rgb: 24'hFFFFFF,
		fixed_brightness: 8'd255,
		sweep_rgb: 24'hFF0000
	};

endpackage

// ----- src/lsep_front.sv -----
module lsep_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lsep_pkg::pixel_t pixel,
	input  lsep_pkg::cfg_t  cfg,
	input  logic            fifo_full,
	output logic            busy,
	output logic            push,
	output lsep_pkg::entry_t entry
);
	import lsep_pkg::*;

	logic                      accept;
	logic                      lit;
	logic [LimitW-1:0]         limit;
	logic signed [RegionW-1:0] span;
	logic signed [RegionW-1:0] mag;
	logic signed [RegionW-1:0] region;
	logic                      valid_s1;
	entry_t                    entry_s1;

	assign busy = valid_s1 && fifo_full;
	assign push = valid_s1 && !fifo_full;
	assign accept = start && !busy;
	assign entry = entry_s1;

	always_comb begin
		limit = LimitW'((pixel.dim_level * LED_COUNT) / DYN_RANGE);
		span = $signed(RegionW'(LED_COUNT)) - $signed({2'b00, pixel.pixel_index, 1'b1});
		mag = (span < 0) ? -span : span;
		region = (cfg.mask_mode == MASK_OUTSIDE_IN) ?
			$signed(RegionW'(LED_COUNT)) - mag : mag;
		case (cfg.mask_mode)
			MASK_GRADUAL: lit = 1'b1;
			MASK_OUTSIDE_IN, MASK_INSIDE_OUT: lit = region < $signed({1'b0, limit});
			MASK_LEFT_RIGHT: lit = LimitW'(pixel.pixel_index) < limit;
			default: lit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.pixel <= pixel;
			entry_s1.lit <= lit;
		end
	end

endmodule

// ----- src/lsep_fifo.sv -----
module lsep_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsep_pkg::entry_t din,
	input  logic             pop,
	output lsep_pkg::entry_t dout,
	output logic             empty,
	output logic             full
);
	import lsep_pkg::*;

	entry_t          mem_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == CntW'(FifoDepth));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("Item pushed into a full queue.");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(FifoDepth))
		else $error("Queue fill count out of range.");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("Pushed item missing from the queue.");
`endif

endmodule

// ----- src/lsep_pos_div.sv -----
module lsep_pos_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  lsep_pkg::entry_t          in_entry,
	input  logic [lsep_pkg::TimeW-1:0] divisor,
	output logic                      out_valid,
	output lsep_pkg::entry_t          out_entry,
	output logic [lsep_pkg::PosW-1:0] pos
);
	import lsep_pkg::*;

	// One quotient bit per stage of {time_now, ten zero bits} / cycle_length.
	// The low ten quotient bits are the cycle position.
	logic                valid_s [DivSteps+1];
	entry_t              entry_s [DivSteps+1];
	logic [TimeW-1:0]    rem_s [DivSteps+1];
	logic [DivSteps-1:0] dvd_s [DivSteps+1];
	logic [PosW-1:0]     quo_s [DivSteps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		entry_s[0] <= in_entry;
		rem_s[0] <= '0;
		dvd_s[0] <= {in_entry.pixel.time_now, PosW'(0)};
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		logic [TimeW:0] shifted;
		logic [TimeW:0] diff;
		logic           ge;

		assign shifted = {rem_s[k], dvd_s[k][DivSteps-1]};
		assign diff = shifted - {1'b0, divisor};
		assign ge = shifted >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			entry_s[k+1] <= entry_s[k];
			rem_s[k+1] <= ge ? TimeW'(diff) : TimeW'(shifted);
			dvd_s[k+1] <= {dvd_s[k][DivSteps-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][PosW-2:0], ge};
		end
	end

	assign out_valid = valid_s[DivSteps];
	assign out_entry = entry_s[DivSteps];
	assign pos = (divisor == '0) ? '0 : quo_s[DivSteps];

endmodule

// ----- src/lsep_back.sv -----
module lsep_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lsep_pkg::entry_t  in_entry,
	input  lsep_pkg::cfg_t    cfg,
	output logic              result_valid,
	output lsep_pkg::result_t result
);
	import lsep_pkg::*;

	logic                     div_valid;
	entry_t                   div_entry;
	logic [PosW-1:0]          pos;
	logic [IndexW:0]          wsum;
	logic [ColorW-1:0]        wp;
	logic [ColorW-1:0]        w;
	logic [ColorW-1:0]        wr;
	logic [ColorW-1:0]        wg;
	logic [ColorW-1:0]        wb;
	logic [PosW:0]            tp;
	logic [IndexW:0]          centre;
	logic signed [SweepW-1:0] lo;
	logic signed [SweepW-1:0] hi;
	logic signed [SweepW-1:0] idx;
	logic                     bright;
	logic [ColorW-1:0]        r;
	logic [ColorW-1:0]        g;
	logic [ColorW-1:0]        b;
	logic [ColorW-1:0]        br;
	logic [ColorW+DimW-1:0]   prod;
	logic [ColorW+DimW-1:0]   scaled;
	result_t                  res;
	logic                     valid_q;
	result_t                  result_q;

	lsep_pos_div u_pos_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_entry  (in_entry),
		.divisor   (cfg.cycle_length),
		.out_valid (div_valid),
		.out_entry (div_entry),
		.pos       (pos)
	);

	always_comb begin
		wsum = {1'b0, div_entry.pixel.pixel_index}
			+ (IndexW+1)'((pos * LED_COUNT) / 1024);
		wp = ColorW'({wsum, 8'b0} / LED_COUNT);
		w = 8'd255 - wp;
		if (w < 8'd85) begin
			wr = 8'd255 - ColorW'(w * 3);
			wg = '0;
			wb = ColorW'(w * 3);
		end else if (w < 8'd170) begin
			wr = '0;
			wg = ColorW'((w - 8'd85) * 3);
			wb = 8'd255 - ColorW'((w - 8'd85) * 3);
		end else begin
			wr = ColorW'((w - 8'd170) * 3);
			wg = 8'd255 - ColorW'((w - 8'd170) * 3);
			wb = '0;
		end

		tp = (pos > PosW'(512)) ? (PosW+1)'(1024) - {1'b0, pos} : {1'b0, pos};
		centre = (IndexW+1)'((tp * LED_COUNT) / 512);
		lo = $signed({2'b00, centre}) - $signed(SweepW'(SWEEP_HALF));
		hi = $signed({2'b00, centre}) + $signed(SweepW'(SWEEP_HALF));
		idx = $signed({3'b000, div_entry.pixel.pixel_index});
		bright = !((idx < lo) || (idx > hi));

		case (cfg.effect_select)
			EFFECT_RAINBOW: begin
				r = wr;
				g = wg;
				b = wb;
				br = cfg.effect_brightness;
			end
			EFFECT_SWEEP: begin
				r = cfg.sweep_rgb[23:16];
				g = cfg.sweep_rgb[15:8];
				b = cfg.sweep_rgb[7:0];
				br = bright ? cfg.effect_brightness : {2'b00, cfg.effect_brightness[7:2]};
			end
			default: begin
				r = cfg.fixed_rgb[23:16];
				g = cfg.fixed_rgb[15:8];
				b = cfg.fixed_rgb[7:0];
				br = cfg.fixed_brightness;
			end
		endcase

		prod = (ColorW+DimW)'(br) * (ColorW+DimW)'(div_entry.pixel.dim_level);
		scaled = (ColorW+DimW)'(prod / DYN_RANGE);
		if (cfg.mask_mode == MASK_GRADUAL) begin
			br = (scaled > (ColorW+DimW)'(255)) ? 8'd255 : ColorW'(scaled);
		end

		res.led_index = div_entry.pixel.pixel_index;
		if (div_entry.lit) begin
			res.red = r;
			res.green = g;
			res.blue = b;
			res.brightness = br;
		end else begin
			res.red = '0;
			res.green = '0;
			res.blue = '0;
			res.brightness = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res;
	end

	assign result_valid = valid_q;
	assign result = result_q;

endmodule

// ----- src/led_strip_effect_pixel_top.sv -----
// LED strip pixel effect generator: one pixel color per item.
// Input: an item (pixel_index, time_now, dim_level) is taken at a rising edge
// where start is high and busy is low. A new item can be taken every cycle.
// Output: each result appears on result for exactly one cycle, marked by
// result_valid; results come out in the order the items were taken.
// Path: the front registers each taken item, the queue stores it, and the back
// registers it and passes it through a 42-stage pipelined restoring divider
// that turns time_now and cycle_length into the cycle position, one quotient
// bit per stage; result and result_valid are registered.
// Throughput: one item per cycle while busy is low; a small queue sits between the front that
// takes items and the back that computes them, and busy rises only if it fills.
// Configuration: registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write only while no item
// is in flight. Unknown indexes are ignored.
// Reset: arst_n clears all items in flight and loads the register defaults.
// The receiver cannot stall: results are never held back.
module led_strip_effect_pixel_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lsep_pkg::pixel_t              pixel,
	output logic                          result_valid,
	output lsep_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsep_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lsep_pkg::CfgDataW-1:0] cfg_data
);
	import lsep_pkg::*;

	cfg_t   cfg_q;
	logic   fifo_full;
	logic   fifo_empty;
	logic   push;
	entry_t front_entry;
	entry_t queue_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EFFECT_SELECT: cfg_q.effect_select <= cfg_data[1:0];
				REG_MASK_MODE: cfg_q.mask_mode <= mask_mode_t'(cfg_data[1:0]);
				REG_CYCLE_LENGTH: cfg_q.cycle_length <= cfg_data[TimeW-1:0];
				REG_EFFECT_BRIGHTNESS: cfg_q.effect_brightness <= cfg_data[ColorW-1:0];
				REG_FIXED_RGB: cfg_q.fixed_rgb <= cfg_data[RgbW-1:0];
				REG_FIXED_BRIGHTNESS: cfg_q.fixed_brightness <= cfg_data[ColorW-1:0];
				REG_SWEEP_RGB: cfg_q.sweep_rgb <= cfg_data[RgbW-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lsep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pixel     (pixel),
		.cfg       (cfg_q),
		.fifo_full (fifo_full),
		.busy      (busy),
		.push      (push),
		.entry     (front_entry)
	);

	lsep_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_entry),
		.pop    (!fifo_empty),
		.dout   (queue_entry),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	lsep_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!fifo_empty),
		.in_entry     (queue_entry),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- tb/tb_led_strip_effect_pixel_top.sv -----
`timescale 1ns / 1ps

module tb_led_strip_effect_pixel_top;
	import lsep_pkg::*;

	localparam longint unsigned LEDS = LED_COUNT;
	localparam longint unsigned RANGE = DYN_RANGE;
	localparam longint SWEEP_REACH = longint'(LED_COUNT / 10);
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] EFFECT_SPARE = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	pixel_t              pixel;
	logic                result_valid;
	result_t             result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cfg_t    shadow_cfg = CFG_RESET;
	result_t pending_colors[$];
	result_t want;
	int      mismatches = 0;
	bit      idle_on = 1'b1;

	led_strip_effect_pixel_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t compute_color(input pixel_t px, input cfg_t c);
		longint unsigned n, t, dim, pos, lim, wp, w, tp, r, g, b, br;
		longint centre, p;
		logic lit;
		result_t res;
		n = 64'(px.pixel_index);
		t = 64'(px.time_now);
		dim = 64'(px.dim_level);
		pos = (c.cycle_length == 0) ? 0 : (t % c.cycle_length) * 1024 / c.cycle_length;
		lim = dim * LEDS / RANGE;
		lit = 1'b1;
		case (c.effect_select)
			EFFECT_RAINBOW: begin
				wp = ((n + pos * LEDS / 1024) * 256 / LEDS) & 255;
				w = 255 - wp;
				if (w < 85) begin
					r = 255 - w * 3;
					g = 0;
					b = w * 3;
				end else if (w < 170) begin
					w -= 85;
					r = 0;
					g = w * 3;
					b = 255 - w * 3;
				end else begin
					w -= 170;
					r = w * 3;
					g = 255 - w * 3;
					b = 0;
				end
				br = 64'(c.effect_brightness);
			end
			EFFECT_SWEEP: begin
				tp = (pos > 512) ? 1024 - pos : pos;
				centre = longint'(tp * LEDS / 512);
				r = 64'(c.sweep_rgb[23:16]);
				g = 64'(c.sweep_rgb[15:8]);
				b = 64'(c.sweep_rgb[7:0]);
				if (longint'(n) < centre - SWEEP_REACH || longint'(n) > centre + SWEEP_REACH)
					br = 64'(c.effect_brightness) / 4;
				else
					br = 64'(c.effect_brightness);
			end
			default: begin
				r = 64'(c.fixed_rgb[23:16]);
				g = 64'(c.fixed_rgb[15:8]);
				b = 64'(c.fixed_rgb[7:0]);
				br = 64'(c.fixed_brightness);
			end
		endcase
		case (c.mask_mode)
			MASK_GRADUAL: begin
				br = br * dim / RANGE;
				if (br > 255)
					br = 255;
			end
			MASK_OUTSIDE_IN, MASK_INSIDE_OUT: begin
				p = longint'(LEDS) - 2 * longint'(n) - 1;
				if (p < 0)
					p = -p;
				if (c.mask_mode == MASK_OUTSIDE_IN)
					p = longint'(LEDS) - p;
				lit = p < longint'(lim);
			end
			default: lit = n < lim;
		endcase
		res.led_index = px.pixel_index;
		res.red = lit ? r[7:0] : 8'd0;
		res.green = lit ? g[7:0] : 8'd0;
		res.blue = lit ? b[7:0] : 8'd0;
		res.brightness = lit ? br[7:0] : 8'd0;
		return res;
	endfunction

	function automatic pixel_t make_pixel(input int unsigned idx, input int unsigned t,
		input int unsigned dim);
		pixel_t px;
		px.pixel_index = idx[IndexW-1:0];
		px.time_now = t;
		px.dim_level = dim[DimW-1:0];
		return px;
	endfunction

	function automatic pixel_t random_pixel();
		int unsigned idx, t, dim;
		case ($urandom_range(0, 9))
			0: idx = $urandom_range(0, 65535);
			1: idx = $urandom_range(LED_COUNT, 255);
			default: idx = $urandom_range(0, LED_COUNT - 1);
		endcase
		t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50000) : $urandom;
		dim = ($urandom_range(0, 9) < 7) ? $urandom_range(0, DYN_RANGE) : $urandom_range(0, 511);
		return make_pixel(idx, t, dim);
	endfunction

	function automatic logic [ColorW-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return ColorW'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_colors.size() == 0) begin
				$error("led_index: expected no result, got %0d", result.led_index);
				mismatches++;
			end else begin
				want = pending_colors.pop_front();
				check_field("led_index", int'(want.led_index), int'(result.led_index));
				check_field("red", int'(want.red), int'(result.red));
				check_field("green", int'(want.green), int'(result.green));
				check_field("blue", int'(want.blue), int'(result.blue));
				check_field("brightness", int'(want.brightness), int'(result.brightness));
			end
		end
	end

	task automatic send_pixel(input pixel_t px);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 26) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (busy);
		pending_colors.push_back(compute_color(px, shadow_cfg));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_EFFECT_SELECT: shadow_cfg.effect_select = data[1:0];
			REG_MASK_MODE: shadow_cfg.mask_mode = mask_mode_t'(data[1:0]);
			REG_CYCLE_LENGTH: shadow_cfg.cycle_length = data;
			REG_EFFECT_BRIGHTNESS: shadow_cfg.effect_brightness = data[7:0];
			REG_FIXED_RGB: shadow_cfg.fixed_rgb = data[23:0];
			REG_FIXED_BRIGHTNESS: shadow_cfg.fixed_brightness = data[7:0];
			REG_SWEEP_RGB: shadow_cfg.sweep_rgb = data[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic randomize_config();
		logic [CfgDataW-1:0] cl;
		case ($urandom_range(0, 4))
			0: cl = 32'd1;
			1: cl = 32'hFFFF_FFFF;
			2: cl = $urandom_range(1, 4096);
			default: cl = $urandom;
		endcase
		write_reg(REG_EFFECT_SELECT, $urandom_range(0, 3));
		write_reg(REG_MASK_MODE, $urandom_range(0, 3));
		write_reg(REG_CYCLE_LENGTH, cl);
		write_reg(REG_EFFECT_BRIGHTNESS, {24'($urandom_range(0, 255)), pick_level()});
		write_reg(REG_FIXED_RGB, $urandom);
		write_reg(REG_FIXED_BRIGHTNESS, CfgDataW'(pick_level()));
		write_reg(REG_SWEEP_RGB, $urandom);
		write_reg(REG_UNUSED, $urandom);
	endtask

	task automatic test_reset_values();
		send_pixel(make_pixel(0, 0, 256));
		send_pixel(make_pixel(31, 32'hFFFF_FFFF, 128));
		send_pixel(make_pixel(63, 12345, 0));
	endtask

	task automatic test_effect_modes();
		wait_idle();
		write_reg(REG_MASK_MODE, CfgDataW'(MASK_GRADUAL));
		write_reg(REG_EFFECT_SELECT, CfgDataW'(EFFECT_RAINBOW));
		write_reg(REG_CYCLE_LENGTH, 1024);
		write_reg(REG_EFFECT_BRIGHTNESS, 200);
		send_pixel(make_pixel(0, 0, 256));
		send_pixel(make_pixel(17, 300, 256));
		send_pixel(make_pixel(63, 1023, 511));
		wait_idle();
		write_reg(REG_EFFECT_SELECT, CfgDataW'(EFFECT_SWEEP));
		write_reg(REG_SWEEP_RGB, 32'h0012_AB34);
		send_pixel(make_pixel(32, 512, 256));
		send_pixel(make_pixel(0, 700, 256));
		send_pixel(make_pixel(6, 0, 256));
		wait_idle();
		// The spare selector code falls back to the fixed color.
		write_reg(REG_EFFECT_SELECT, CfgDataW'(EFFECT_SPARE));
		send_pixel(make_pixel(5, 77, 100));
	endtask

	task automatic test_mask_modes();
		wait_idle();
		write_reg(REG_EFFECT_SELECT, CfgDataW'(EFFECT_FIXED));
		write_reg(REG_FIXED_RGB, 32'h0000_FF80);
		write_reg(REG_FIXED_BRIGHTNESS, 255);
		write_reg(REG_MASK_MODE, CfgDataW'(MASK_GRADUAL));
		send_pixel(make_pixel(1, 0, 511));
		wait_idle();
		write_reg(REG_MASK_MODE, CfgDataW'(MASK_OUTSIDE_IN));
		send_pixel(make_pixel(64, 0, 256));
		send_pixel(make_pixel(65535, 0, 511));
		wait_idle();
		write_reg(REG_MASK_MODE, CfgDataW'(MASK_INSIDE_OUT));
		send_pixel(make_pixel(31, 0, 64));
		send_pixel(make_pixel(0, 0, 511));
		wait_idle();
		write_reg(REG_MASK_MODE, CfgDataW'(MASK_LEFT_RIGHT));
		send_pixel(make_pixel(63, 0, 256));
		send_pixel(make_pixel(10, 0, 40));
		send_pixel(make_pixel(65535, 0, 511));
	endtask

	task automatic test_cycle_extremes();
		wait_idle();
		write_reg(REG_EFFECT_SELECT, CfgDataW'(EFFECT_RAINBOW));
		write_reg(REG_EFFECT_BRIGHTNESS, 0);
		// A zero period pins the animation at its first position.
		write_reg(REG_CYCLE_LENGTH, 0);
		send_pixel(make_pixel(3, 32'hFFFF_FFFF, 256));
		wait_idle();
		write_reg(REG_CYCLE_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_EFFECT_BRIGHTNESS, 255);
		send_pixel(make_pixel(3, 32'hFFFF_FFFE, 256));
		wait_idle();
		write_reg(REG_EFFECT_SELECT, CfgDataW'(EFFECT_SWEEP));
		write_reg(REG_CYCLE_LENGTH, 1);
		send_pixel(make_pixel(2, 999, 256));
		wait_idle();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_pixel(make_pixel(3, 0, 256));
	endtask

	task automatic test_random_phases(input int phases, input int items);
		for (int ph = 0; ph < phases; ph++) begin
			wait_idle();
			randomize_config();
			repeat (items) send_pixel(random_pixel());
		end
	endtask

	task automatic test_back_to_back(input int items);
		wait_idle();
		randomize_config();
		idle_on = 1'b0;
		repeat (items) send_pixel(random_pixel());
		wait_idle();
		repeat (items) send_pixel(random_pixel());
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_effect_modes();
		test_mask_modes();
		test_cycle_extremes();
		test_random_phases(9, 100);
		test_back_to_back(125);
		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
